>>> hdl/dvm_pkg.sv
package dvm_pkg;

	// shared divider widths: widest dividend is adc * supply * (upper + lower) + den / 2
	localparam int DIV_NUM_W = 54;
	localparam int DIV_DEN_W = 36;
	localparam int DIV_CNT_W = $clog2(DIV_NUM_W + 1);

	localparam int SAMPLE_W = 12;
	localparam int MV_W     = 16;
	localparam int RES_W    = 24;

	// 4095 * 1200, full-scale code times the reference millivolts
	localparam logic [22:0] SUPPLY_SCALE = 23'd4914000;
	localparam logic [MV_W-1:0] MV_MAX   = 16'hFFFF;

	localparam logic SRC_REFERENCE = 1'b0;
	localparam logic SRC_DIVIDER   = 1'b1;

	localparam logic REG_UPPER = 1'b0;
	localparam logic REG_LOWER = 1'b1;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_REF_AVG,
		ST_DIV_AVG,
		ST_SUPPLY,
		ST_MUL_A,
		ST_MUL_B,
		ST_MEAS_START,
		ST_MEAS,
		ST_OUT
	} state_t;

endpackage

>>> hdl/dvm_div.sv
// restoring divider, one quotient bit per cycle
module dvm_div (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  logic [dvm_pkg::DIV_NUM_W-1:0] num,
	input  logic [dvm_pkg::DIV_DEN_W-1:0] den,
	output logic                          done,
	output logic [dvm_pkg::DIV_NUM_W-1:0] quo
);

	logic [dvm_pkg::DIV_NUM_W-1:0] n_q;
	logic [dvm_pkg::DIV_DEN_W-1:0] r_q;
	logic [dvm_pkg::DIV_DEN_W-1:0] d_q;
	logic [dvm_pkg::DIV_CNT_W-1:0] cnt_q;
	logic                          busy_q;
	logic                          done_q;

	logic [dvm_pkg::DIV_DEN_W:0] trial;
	logic [dvm_pkg::DIV_DEN_W:0] diff;
	logic                        ge;

	assign trial = {r_q, n_q[dvm_pkg::DIV_NUM_W-1]};
	assign diff  = trial - {1'b0, d_q};
	assign ge    = trial >= {1'b0, d_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= dvm_pkg::DIV_CNT_W'(dvm_pkg::DIV_NUM_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == dvm_pkg::DIV_CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			n_q <= num;
			r_q <= '0;
			d_q <= den;
		end else if (busy_q) begin
			n_q <= {n_q[dvm_pkg::DIV_NUM_W-2:0], ge};
			r_q <= ge ? diff[dvm_pkg::DIV_DEN_W-1:0] : trial[dvm_pkg::DIV_DEN_W-1:0];
		end
	end

	assign done = done_q;
	assign quo  = n_q;

endmodule

>>> hdl/divider_voltage_monitor.sv
// a word that does not close a set is only accumulated; a closing divider word starts the
//   two averages and, for a valid set, the supply and node quotients, all on the shared
//   bit-serial divider (an invalid set stops after the two averages)
// throughput: one word per cycle between sets, none while a set is computed or output
// reset: arst_n clears the resistor registers, all channel sums, counts and zero flags,
//   the sequencer and the output valid
module divider_voltage_monitor #(
	parameter int SAMPLES_PER_SET = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	// configuration port
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	// input word
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [15:0] s_tdata,   // [11:0] sample, [15:12] zero
	input  logic [0:0]  s_tuser,   // [0] source
	// result word
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [31:0] m_tdata,   // [15:0] supply_mv, [31:16] node_mv
	output logic [0:0]  m_tuser    // [0] valid_res
);

	localparam int CNT_W = $clog2(SAMPLES_PER_SET + 1);
	localparam int SUM_W = dvm_pkg::SAMPLE_W + $clog2(SAMPLES_PER_SET);
	localparam int NW    = dvm_pkg::DIV_NUM_W;
	localparam int DW    = dvm_pkg::DIV_DEN_W;

	// configuration registers
	logic [dvm_pkg::RES_W-1:0] upper_q;
	logic [dvm_pkg::RES_W-1:0] lower_q;
	logic                      cfg_wr;

	assign pready = 1'b1;
	assign cfg_wr = psel & penable & pwrite & pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			upper_q <= '0;
			lower_q <= '0;
		end else if (cfg_wr) begin
			if (paddr[2] == dvm_pkg::REG_UPPER) begin
				upper_q <= pwdata[dvm_pkg::RES_W-1:0];
			end else begin
				lower_q <= pwdata[dvm_pkg::RES_W-1:0];
			end
		end
	end

	// registers are word addressed, only paddr[2] selects
	assign prdata = (paddr[2] == dvm_pkg::REG_UPPER) ? {8'd0, upper_q} : {8'd0, lower_q};

	// sequencer
	dvm_pkg::state_t state_q, state_d;

	logic                          accept;
	logic                          set_done;
	logic                          out_load;
	logic                          div_start;
	logic [NW-1:0]                 div_num;
	logic [DW-1:0]                 div_den;
	logic                          div_done;
	logic [NW-1:0]                 div_quo;

	// per-channel accumulators
	logic [SUM_W-1:0] ref_sum_q;
	logic [CNT_W-1:0] ref_cnt_q;
	logic             ref_zero_q;
	logic [SUM_W-1:0] div_sum_q;
	logic [CNT_W-1:0] div_cnt_q;
	logic             div_zero_q;

	// computation registers
	logic [dvm_pkg::SAMPLE_W-1:0] ref_avg_q;
	logic [dvm_pkg::SAMPLE_W-1:0] div_avg_q;
	logic [dvm_pkg::SAMPLE_W-1:0] ref_avg_d;
	logic [dvm_pkg::SAMPLE_W-1:0] div_avg_d;
	logic [dvm_pkg::MV_W-1:0]     supply_q;
	logic [dvm_pkg::MV_W-1:0]     meas_q;
	logic [dvm_pkg::MV_W-1:0]     quo_sat;
	logic                         res_valid_q;
	logic                         invalid;
	logic [27:0]                  prod_a_q;
	logic [52:0]                  prod_b_q;
	logic [dvm_pkg::RES_W:0]      res_total;
	logic [DW-1:0]                meas_den;
	logic [NW-1:0]                meas_num;
	logic [NW-1:0]                supply_num;

	// output register
	logic                     m_valid_q;
	logic [31:0]              m_data_q;
	logic                     m_flag_q;

	assign s_tready = (state_q == dvm_pkg::ST_IDLE);
	assign accept   = s_tvalid & s_tready;
	// the divider word that fills the divider channel closes the set
	assign set_done = accept && (s_tuser[0] == dvm_pkg::SRC_DIVIDER) &&
		(div_cnt_q + 1'b1 == CNT_W'(SAMPLES_PER_SET));
	assign out_load = (state_q == dvm_pkg::ST_OUT) && (!m_valid_q || m_tready);

	// averages; a zero sample or an empty channel forces a zero average
	assign ref_avg_d = (ref_zero_q || ref_cnt_q == '0) ? '0 : div_quo[dvm_pkg::SAMPLE_W-1:0];
	assign div_avg_d = div_zero_q ? '0 : div_quo[dvm_pkg::SAMPLE_W-1:0];
	assign invalid   = (ref_avg_q == '0) || (div_avg_d == '0) || (lower_q == '0);

	// saturate a quotient to 16 bits
	assign quo_sat = (div_quo[NW-1:dvm_pkg::MV_W] != '0) ? dvm_pkg::MV_MAX :
		div_quo[dvm_pkg::MV_W-1:0];

	// rounding terms: dividend plus half the divisor
	assign supply_num = NW'(dvm_pkg::SUPPLY_SCALE) + NW'(ref_avg_q >> 1);
	assign res_total  = {1'b0, upper_q} + {1'b0, lower_q};
	// 4095 * lower as a shift and subtract
	assign meas_den   = {lower_q, 12'd0} - {12'd0, lower_q};
	assign meas_num   = {1'b0, prod_b_q} + {1'b0, meas_den[DW-1:1]};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= dvm_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d   = state_q;
		div_start = 1'b0;
		div_num   = '0;
		div_den   = '0;
		unique case (state_q)
			dvm_pkg::ST_IDLE: begin
				if (set_done) begin
					div_start = 1'b1;
					div_num   = NW'(ref_sum_q);
					div_den   = DW'(ref_cnt_q);
					state_d   = dvm_pkg::ST_REF_AVG;
				end
			end
			dvm_pkg::ST_REF_AVG: begin
				if (div_done) begin
					div_start = 1'b1;
					div_num   = NW'(div_sum_q);
					div_den   = DW'(SAMPLES_PER_SET);
					state_d   = dvm_pkg::ST_DIV_AVG;
				end
			end
			dvm_pkg::ST_DIV_AVG: begin
				if (div_done) begin
					if (invalid) begin
						state_d = dvm_pkg::ST_OUT;
					end else begin
						div_start = 1'b1;
						div_num   = supply_num;
						div_den   = DW'(ref_avg_q);
						state_d   = dvm_pkg::ST_SUPPLY;
					end
				end
			end
			dvm_pkg::ST_SUPPLY: begin
				if (div_done) begin
					state_d = dvm_pkg::ST_MUL_A;
				end
			end
			dvm_pkg::ST_MUL_A: begin
				state_d = dvm_pkg::ST_MUL_B;
			end
			dvm_pkg::ST_MUL_B: begin
				state_d = dvm_pkg::ST_MEAS_START;
			end
			dvm_pkg::ST_MEAS_START: begin
				div_start = 1'b1;
				div_num   = meas_num;
				div_den   = meas_den;
				state_d   = dvm_pkg::ST_MEAS;
			end
			dvm_pkg::ST_MEAS: begin
				if (div_done) begin
					state_d = dvm_pkg::ST_OUT;
				end
			end
			dvm_pkg::ST_OUT: begin
				if (out_load) begin
					state_d = dvm_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = dvm_pkg::ST_IDLE;
			end
		endcase
	end

	// the one divider shared by all four quotients
	dvm_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (div_num),
		.den    (div_den),
		.done   (div_done),
		.quo    (div_quo)
	);

	// channel accumulators, cleared once the result is loaded
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ref_sum_q  <= '0;
			ref_cnt_q  <= '0;
			ref_zero_q <= 1'b0;
			div_sum_q  <= '0;
			div_cnt_q  <= '0;
			div_zero_q <= 1'b0;
		end else if (out_load) begin
			ref_sum_q  <= '0;
			ref_cnt_q  <= '0;
			ref_zero_q <= 1'b0;
			div_sum_q  <= '0;
			div_cnt_q  <= '0;
			div_zero_q <= 1'b0;
		end else if (accept) begin
			if (s_tuser[0] == dvm_pkg::SRC_REFERENCE) begin
				// extra reference words beyond a full set are dropped
				if (ref_cnt_q < CNT_W'(SAMPLES_PER_SET)) begin
					ref_sum_q <= ref_sum_q + SUM_W'(s_tdata[dvm_pkg::SAMPLE_W-1:0]);
					ref_cnt_q <= ref_cnt_q + 1'b1;
					if (s_tdata[dvm_pkg::SAMPLE_W-1:0] == '0) begin
						ref_zero_q <= 1'b1;
					end
				end
			end else begin
				div_sum_q <= div_sum_q + SUM_W'(s_tdata[dvm_pkg::SAMPLE_W-1:0]);
				div_cnt_q <= div_cnt_q + 1'b1;
				if (s_tdata[dvm_pkg::SAMPLE_W-1:0] == '0) begin
					div_zero_q <= 1'b1;
				end
			end
		end
	end

	// computation datapath
	always_ff @(posedge clk) begin
		if (state_q == dvm_pkg::ST_REF_AVG && div_done) begin
			ref_avg_q <= ref_avg_d;
		end
		if (state_q == dvm_pkg::ST_DIV_AVG && div_done) begin
			div_avg_q   <= div_avg_d;
			res_valid_q <= !invalid;
			// invalid set reports zeros
			supply_q    <= '0;
			meas_q      <= '0;
		end
		if (state_q == dvm_pkg::ST_SUPPLY && div_done) begin
			supply_q <= quo_sat;
		end
		// adc average times supply, then times the divider total
		if (state_q == dvm_pkg::ST_MUL_A) begin
			prod_a_q <= div_avg_q * supply_q;
		end
		if (state_q == dvm_pkg::ST_MUL_B) begin
			prod_b_q <= prod_a_q * res_total;
		end
		if (state_q == dvm_pkg::ST_MEAS && div_done) begin
			meas_q <= quo_sat;
		end
	end

	// output register, holds a finished word until taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (out_load) begin
			m_valid_q <= 1'b1;
		end else if (m_tready) begin
			m_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			m_data_q <= {meas_q, supply_q};
			m_flag_q <= res_valid_q;
		end
	end

	assign m_tvalid   = m_valid_q;
	assign m_tdata    = m_data_q;
	assign m_tuser[0] = m_flag_q;

endmodule

>>> test/voltage_reading_checker.sv
module voltage_reading_checker (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [2:0]        paddr,
	input  logic [31:0]       pwdata,
	input  logic              pready,
	input  logic              s_tvalid,
	input  logic              s_tready,
	input  logic [15:0]       s_tdata,   // [11:0] sample, [15:12] zero
	input  logic [0:0]        s_tuser,   // [0] source
	input  logic              m_tvalid,
	input  logic              m_tready,
	input  logic [31:0]       m_tdata,   // [15:0] supply_mv, [31:16] node_mv
	input  logic [0:0]        m_tuser,   // [0] valid_res
	output int                errors,
	output int                outstanding
);

	localparam int SAMPLE_W     = dvm_pkg::SAMPLE_W;
	localparam int MV_W         = dvm_pkg::MV_W;
	localparam int RES_W        = dvm_pkg::RES_W;
	localparam int SET_SIZE     = 16;
	localparam int REPORT_LIMIT = 10;
	localparam logic [SAMPLE_W-1:0] FULL_SCALE = 12'd4095;

	typedef struct packed {
		logic [MV_W-1:0] supply_mv;
		logic [MV_W-1:0] node_mv;
		logic            valid_res;
	} reading_t;

	reading_t expected_readings[$];

	logic [RES_W-1:0] upper_ohms;
	logic [RES_W-1:0] lower_ohms;
	logic [15:0]      ref_sum;
	logic [4:0]       ref_cnt;
	logic             ref_zero;
	logic [15:0]      div_sum;
	logic [4:0]       div_cnt;
	logic             div_zero;

	task automatic clear_sets();
		ref_sum  = '0;
		ref_cnt  = '0;
		ref_zero = 1'b0;
		div_sum  = '0;
		div_cnt  = '0;
		div_zero = 1'b0;
	endtask

	// supply from the reference average, then the divider input from the supply
	function automatic reading_t voltages_from_set(input logic [SAMPLE_W-1:0] ref_avg,
			input logic [SAMPLE_W-1:0] div_avg, input logic [RES_W-1:0] upper,
			input logic [RES_W-1:0] lower);
		reading_t    r;
		logic [31:0] supply;
		logic [63:0] num;
		logic [63:0] den;
		logic [63:0] meas;
		r = '0;
		if (ref_avg == 0 || div_avg == 0 || lower == 0)
			return r;
		supply = (32'(dvm_pkg::SUPPLY_SCALE) + 32'(ref_avg / 2)) / 32'(ref_avg);
		if (supply > 32'(dvm_pkg::MV_MAX))
			supply = 32'(dvm_pkg::MV_MAX);
		num  = 64'(div_avg) * 64'(supply) * (64'(upper) + 64'(lower));
		den  = 64'(FULL_SCALE) * 64'(lower);
		meas = (num + den / 2) / den;
		if (meas > 64'(dvm_pkg::MV_MAX))
			meas = 64'(dvm_pkg::MV_MAX);
		r.supply_mv = supply[MV_W-1:0];
		r.node_mv   = meas[MV_W-1:0];
		r.valid_res = 1'b1;
		return r;
	endfunction

	task automatic fold_word(input logic [SAMPLE_W-1:0] sample, input logic source);
		logic [SAMPLE_W-1:0] ref_avg;
		logic [SAMPLE_W-1:0] div_avg;
		if (source == dvm_pkg::SRC_REFERENCE) begin
			// reference words past a full set are dropped
			if (ref_cnt < SET_SIZE) begin
				ref_sum = ref_sum + 16'(sample);
				ref_cnt = ref_cnt + 5'd1;
				if (sample == 0)
					ref_zero = 1'b1;
			end
		end else begin
			div_sum = div_sum + 16'(sample);
			div_cnt = div_cnt + 5'd1;
			if (sample == 0)
				div_zero = 1'b1;
			if (div_cnt == SET_SIZE) begin
				ref_avg = (ref_zero || ref_cnt == 0) ? '0 : SAMPLE_W'(ref_sum / 16'(ref_cnt));
				div_avg = div_zero ? '0 : SAMPLE_W'(div_sum / 16'(div_cnt));
				expected_readings.push_back(voltages_from_set(ref_avg, div_avg,
					upper_ohms, lower_ohms));
				clear_sets();
			end
		end
	endtask

	task automatic check_reading(input reading_t got);
		reading_t want;
		if (expected_readings.size() == 0) begin
			errors++;
			if (errors <= REPORT_LIMIT)
				$display("unexpected result word: supply %0d node %0d valid %0d",
					got.supply_mv, got.node_mv, got.valid_res);
		end else begin
			want = expected_readings.pop_front();
			if (got.supply_mv !== want.supply_mv || got.node_mv !== want.node_mv ||
					got.valid_res !== want.valid_res) begin
				errors++;
				if (errors <= REPORT_LIMIT)
					$display("result mismatch: expected %0d %0d %0d, got %0d %0d %0d",
						want.supply_mv, want.node_mv, want.valid_res,
						got.supply_mv, got.node_mv, got.valid_res);
			end
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			upper_ohms = '0;
			lower_ohms = '0;
			clear_sets();
			expected_readings.delete();
			errors = 0;
		end else begin
			if (psel && penable && pwrite && pready) begin
				case (paddr[2])
					dvm_pkg::REG_UPPER: upper_ohms = pwdata[RES_W-1:0];
					dvm_pkg::REG_LOWER: lower_ohms = pwdata[RES_W-1:0];
				endcase
			end
			if (m_tvalid && m_tready)
				check_reading('{supply_mv: m_tdata[15:0], node_mv: m_tdata[31:16],
					valid_res: m_tuser[0]});
			if (s_tvalid && s_tready)
				fold_word(s_tdata[SAMPLE_W-1:0], s_tuser[0]);
		end
		outstanding = expected_readings.size();
	end

endmodule

>>> test/divider_voltage_monitor_tb.sv
module divider_voltage_monitor_tb;

	localparam int SAMPLE_W    = dvm_pkg::SAMPLE_W;
	localparam int RES_W       = dvm_pkg::RES_W;
	localparam int SET_SIZE    = 16;
	localparam int WORD_TARGET = 1350;   // random words after the directed part
	localparam int PHASE_WORDS = 110;    // words between configuration changes
	localparam int SETTLE      = 8;
	localparam int DRAIN       = 300;    // outlasts the computation a closing divider word starts
	localparam logic [RES_W-1:0] RES_FULL = 24'hFFFFFF;

	// ways to build one set of words
	typedef enum int {
		SHAPE_PLAIN,
		SHAPE_REF_ZERO,
		SHAPE_DIV_ZERO,
		SHAPE_NO_REF,
		SHAPE_EXTRA_REF,
		SHAPE_TINY_REF,
		SHAPE_WILD,
		SHAPE_NOISE
	} set_shape_t;

	logic        clk;
	logic        arst_n;
	logic        psel;
	logic        penable;
	logic        pwrite;
	logic [2:0]  paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic        pready;
	logic        s_tvalid;
	logic        s_tready;
	logic [15:0] s_tdata;    // [11:0] sample, [15:12] zero
	logic [0:0]  s_tuser;    // [0] source
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [31:0] m_tdata;    // [15:0] supply_mv, [31:16] node_mv
	logic [0:0]  m_tuser;    // [0] valid_res

	int errors;
	int outstanding;
	int words_sent;

	// result side stall state
	int sink_stall = 0;
	bit sink_calm  = 1'b0;

	divider_voltage_monitor #(
		.SAMPLES_PER_SET(SET_SIZE)
	) DUT (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata (s_tdata),
		.s_tuser (s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata (m_tdata),
		.m_tuser (m_tuser)
	);

	voltage_reading_checker readings (
		.clk        (clk),
		.arst_n     (arst_n),
		.psel       (psel),
		.penable    (penable),
		.pwrite     (pwrite),
		.paddr      (paddr),
		.pwdata     (pwdata),
		.pready     (pready),
		.s_tvalid   (s_tvalid),
		.s_tready   (s_tready),
		.s_tdata    (s_tdata),
		.s_tuser    (s_tuser),
		.m_tvalid   (m_tvalid),
		.m_tready   (m_tready),
		.m_tdata    (m_tdata),
		.m_tuser    (m_tuser),
		.errors     (errors),
		.outstanding(outstanding)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// hard stop well beyond the slowest legal run
	initial begin
		#8000000;
		$display("CHECKS FAILED");
		$finish;
	end

	// mostly no gap, often a short one, now and then a long one
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 60)
			return 0;
		else if (r < 92)
			return $urandom_range(1, 3);
		else
			return $urandom_range(8, 40);
	endfunction

	// sample near a base level, never zero
	function automatic logic [SAMPLE_W-1:0] near(input int base, input int spread);
		int v;
		v = base + int'($urandom_range(0, 2 * spread)) - spread;
		if (v < 1)
			v = 1;
		if (v > 4095)
			v = 4095;
		return v[SAMPLE_W-1:0];
	endfunction

	// result side: ready drops for random stretches, with calm periods of no stall
	always @(negedge clk) begin
		if ($urandom_range(0, 299) == 0)
			sink_calm = !sink_calm;
		if (sink_stall > 0) begin
			m_tready <= 1'b0;
			sink_stall = sink_stall - 1;
		end else begin
			m_tready <= 1'b1;
			if (!sink_calm)
				sink_stall = pick_gap();
		end
	end

	// called at a falling edge, returns at the falling edge after the word is taken
	task automatic send_word(input logic [SAMPLE_W-1:0] sample, input logic source,
			input bit no_gaps);
		int gap;
		gap = no_gaps ? 0 : pick_gap();
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= {{(16 - SAMPLE_W){1'b0}}, sample};
		s_tuser  <= source;
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		@(negedge clk);
		words_sent++;
	endtask

	// setup cycle then access cycle, bus left idle after
	task automatic write_reg(input logic idx, input logic [RES_W-1:0] value);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {idx, 2'b00};
		pwdata  <= {{(32 - RES_W){1'b0}}, value};
		@(negedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready)
			@(posedge clk);
		@(negedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		@(negedge clk);
	endtask

	// no words in flight and every expected result delivered
	task automatic wait_idle();
		s_tvalid <= 1'b0;
		while (outstanding != 0)
			@(negedge clk);
		repeat (SETTLE) @(negedge clk);
	endtask

	// resistor settings rotate through the extremes and random values
	task automatic configure_phase(input int phase);
		logic [RES_W-1:0] upper;
		logic [RES_W-1:0] lower;
		case (phase % 7)
			0: begin
				upper = '0;
				lower = RES_FULL;
			end
			1: begin
				upper = RES_FULL;
				lower = RES_FULL;
			end
			2: begin
				upper = RES_FULL;
				lower = 24'd1;
			end
			3: begin
				// lower resistor zero forces invalid results
				upper = RES_W'($urandom_range(0, RES_FULL));
				lower = '0;
			end
			4: begin
				upper = RES_W'($urandom);
				lower = RES_W'($urandom);
			end
			default: begin
				// realistic ratios, mostly unsaturated
				lower = RES_W'($urandom_range(1, RES_FULL));
				upper = RES_W'($urandom_range(0, RES_FULL) >> $urandom_range(0, 20));
			end
		endcase
		write_reg(dvm_pkg::REG_UPPER, upper);
		write_reg(dvm_pkg::REG_LOWER, lower);
	endtask

	// one set of mixed words, a divider word last; the noise shape sends loose words
	task automatic send_set(input set_shape_t shape, input bit no_gaps);
		int ref_left;
		int div_left;
		int ref_base;
		int div_base;
		int spread;
		int ref_zero_at;
		int div_zero_at;
		int n;
		logic [SAMPLE_W-1:0] sample;
		ref_base    = $urandom_range(1, 4095);
		div_base    = $urandom_range(1, 4095);
		spread      = $urandom_range(0, 64);
		ref_zero_at = -1;
		div_zero_at = -1;
		div_left    = SET_SIZE;
		case (shape)
			SHAPE_NOISE: begin
				// loose words of any source, may or may not close a set
				n = $urandom_range(1, 12);
				repeat (n)
					send_word(SAMPLE_W'($urandom_range(0, 4095)), 1'($urandom_range(0, 1)),
						no_gaps);
				return;
			end
			SHAPE_NO_REF:    ref_left = 0;
			SHAPE_EXTRA_REF: ref_left = $urandom_range(SET_SIZE + 1, SET_SIZE + 8);
			default:         ref_left = $urandom_range(1, SET_SIZE);
		endcase
		// tiny reference average drives the supply past 16 bits
		if (shape == SHAPE_TINY_REF) begin
			ref_base = 1;
			spread   = 1;
		end
		if (shape == SHAPE_REF_ZERO)
			ref_zero_at = $urandom_range(0, ref_left - 1);
		if (shape == SHAPE_DIV_ZERO)
			div_zero_at = $urandom_range(0, SET_SIZE - 1);
		while (div_left > 0) begin
			if (ref_left > 0 && (div_left == 1 ||
					$urandom_range(0, ref_left + div_left - 1) < ref_left)) begin
				ref_left--;
				if (shape == SHAPE_WILD)
					sample = SAMPLE_W'($urandom_range(0, 4095));
				else if (ref_left == ref_zero_at)
					sample = '0;
				else
					sample = near(ref_base, spread);
				send_word(sample, dvm_pkg::SRC_REFERENCE, no_gaps);
			end else begin
				div_left--;
				if (shape == SHAPE_WILD)
					sample = SAMPLE_W'($urandom_range(0, 4095));
				else if (div_left == div_zero_at)
					sample = '0;
				else
					sample = near(div_base, spread);
				send_word(sample, dvm_pkg::SRC_DIVIDER, no_gaps);
			end
		end
	endtask

	function automatic set_shape_t pick_shape();
		int r;
		r = $urandom_range(0, 99);
		if (r < 45)
			return SHAPE_PLAIN;
		else if (r < 53)
			return SHAPE_REF_ZERO;
		else if (r < 61)
			return SHAPE_DIV_ZERO;
		else if (r < 67)
			return SHAPE_NO_REF;
		else if (r < 75)
			return SHAPE_EXTRA_REF;
		else if (r < 83)
			return SHAPE_TINY_REF;
		else if (r < 93)
			return SHAPE_WILD;
		else
			return SHAPE_NOISE;
	endfunction

	initial begin
		int phase;
		int phase_end;
		arst_n     = 1'b0;
		psel       = 1'b0;
		penable    = 1'b0;
		pwrite     = 1'b0;
		paddr      = '0;
		pwdata     = '0;
		s_tvalid   = 1'b0;
		s_tdata    = '0;
		s_tuser    = '0;
		words_sent = 0;
		repeat (3) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// directed: full-scale divider against a near-zero reference saturates both outputs
		write_reg(dvm_pkg::REG_UPPER, RES_FULL);
		write_reg(dvm_pkg::REG_LOWER, 24'd1);
		send_word(12'd1, dvm_pkg::SRC_REFERENCE, 1'b1);
		send_word(12'd1, dvm_pkg::SRC_REFERENCE, 1'b1);
		repeat (SET_SIZE) send_word(12'hFFF, dvm_pkg::SRC_DIVIDER, 1'b0);
		// zero and full-scale reference words carry into the next set and poison it
		send_word(12'd0, dvm_pkg::SRC_REFERENCE, 1'b0);
		send_word(12'hFFF, dvm_pkg::SRC_REFERENCE, 1'b0);

		// random phases, each under a fresh resistor setting
		words_sent = 0;
		phase = 0;
		while (words_sent < WORD_TARGET) begin
			wait_idle();
			configure_phase(phase);
			phase++;
			phase_end = words_sent + PHASE_WORDS;
			while (words_sent < phase_end && words_sent < WORD_TARGET)
				send_set(pick_shape(), $urandom_range(0, 4) == 0);
		end

		// let the last result drain and make sure nothing extra shows up
		wait_idle();
		repeat (DRAIN) @(negedge clk);
		if (errors == 0 && outstanding == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule
